// ----- rtl/core/olt_pkg.sv -----
// olt_pkg: shared types, codes and sizes for the ordered code list table
// used by olt_cell and ordered_code_list_table; depends on nothing else
`default_nettype none

package olt_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CODE_W = 32;
  localparam int OCC_W = 5;

  // action codes
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_SEARCH = 3'd1;
  localparam logic [2:0] ACT_MODIFY = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_LIST   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // cell value operations
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_SHIFT = 2'd1;
  localparam logic [1:0] CELL_WRITE = 2'd2;
  localparam logic [1:0] CELL_PULL  = 2'd3;

  // cell token operations
  localparam logic [1:0] TOK_HOLD  = 2'd0;
  localparam logic [1:0] TOK_START = 2'd1;
  localparam logic [1:0] TOK_STEP  = 2'd2;
  localparam logic [1:0] TOK_CLEAR = 2'd3;

  typedef struct packed {
    logic [2:0]               action;
    logic signed [CODE_W-1:0] code;
    logic signed [CODE_W-1:0] replacement;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [CODE_W-1:0] value;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  typedef struct packed {
    logic [1:0] value_op;
    logic [1:0] tok_op;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/olt_cell.sv -----
// olt_cell: one list position, holds a code and the scan token
// depends on olt_pkg
`default_nettype none

module olt_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire olt_pkg::cell_ctrl_t              ctrl,
  input  wire logic                             head,
  input  wire logic signed [olt_pkg::CODE_W-1:0] left_value,
  input  wire logic signed [olt_pkg::CODE_W-1:0] right_value,
  input  wire logic                             left_tok,
  input  wire logic signed [olt_pkg::CODE_W-1:0] key,
  input  wire logic signed [olt_pkg::CODE_W-1:0] repl,
  output logic signed [olt_pkg::CODE_W-1:0]     value,
  output logic                                  tok,
  output logic                                  hit
);

  assign hit = tok && (value == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      unique case (ctrl.tok_op)
        olt_pkg::TOK_HOLD:  tok <= tok;
        olt_pkg::TOK_START: tok <= head;
        olt_pkg::TOK_STEP:  tok <= left_tok;
        olt_pkg::TOK_CLEAR: tok <= 1'b0;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    unique case (ctrl.value_op)
      olt_pkg::CELL_HOLD:  value <= value;
      olt_pkg::CELL_SHIFT: value <= left_value;
      olt_pkg::CELL_WRITE: if (tok) value <= repl;
      olt_pkg::CELL_PULL:  if (tok) value <= right_value;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ordered_code_list_table.sv -----
// ordered_code_list_table: top level, sequencer over a row of olt_cell
// depends on olt_pkg and olt_cell
//
// usage
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one beat per action:
//   insert, search, modify, delete or list. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns one beat per action, or one beat per
//   held entry for a list, the final beat carrying last.
//   position 0 of the cell row is the newest code. insert shifts the whole
//   row by one place. search, modify and delete pass a token
//   down the row one cell per cycle and compare at the token; delete then
//   walks the token on, each cell pulling its right neighbor's code.
//   list walks the same token, one beat per cycle unless rsp stalls.
//   insert, full, empty and unused actions go from idle straight to the
//   done state; search, modify and delete walk until a hit or the last
//   entry; a delete hit then pulls on to the last held entry.
//   one action is worked on at a time; cmd_ready is high only when idle.
//   the response register lets a new cmd beat be taken while the last rsp
//   beat still waits; a stalled receiver holds the sequencer in place.
//   reset (rst, synchronous) empties the list and drops any pending beat;
//   cell contents are not cleared, only positions below the count are read.
`default_nettype none

module ordered_code_list_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire olt_pkg::cmd_t cmd,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output olt_pkg::rsp_t      rsp
);

  localparam int DEPTH = olt_pkg::DEPTH;
  localparam int IDX_W = olt_pkg::IDX_W;
  localparam int CNT_W = olt_pkg::CNT_W;
  localparam int CODE_W = olt_pkg::CODE_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PULL = 3'd2;
  localparam logic [2:0] S_LIST = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]               state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         idx, idx_next;
  logic [2:0]               act, act_next;
  logic signed [CODE_W-1:0] key, key_next;
  logic signed [CODE_W-1:0] repl, repl_next;
  logic [1:0]               pend, pend_next;
  olt_pkg::rsp_t            rsp_next;
  logic                     rsp_load;
  olt_pkg::cell_ctrl_t      ctrl;

  // cell row wiring
  logic signed [CODE_W-1:0] values [DEPTH];
  logic signed [CODE_W-1:0] lefts  [DEPTH];
  logic signed [CODE_W-1:0] rights [DEPTH];
  logic [DEPTH-1:0]         toks;
  logic [DEPTH-1:0]         lefts_tok;
  logic [DEPTH-1:0]         hits;
  logic signed [CODE_W-1:0] sel_value;

  logic             any_hit;
  logic             at_last;
  logic             load_ok;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] cnt_m1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // head cell takes the new code on insert, tail cell has nothing to pull
    if (i == 0) begin : g_head
      assign lefts[i]     = cmd.code;
      assign lefts_tok[i] = 1'b0;
    end else begin : g_body
      assign lefts[i]     = values[i-1];
      assign lefts_tok[i] = toks[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rights[i] = '0;
    end else begin : g_mid
      assign rights[i] = values[i+1];
    end

    olt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .head        (1'(i == 0)),
      .left_value  (lefts[i]),
      .right_value (rights[i]),
      .left_tok    (lefts_tok[i]),
      .key         (key),
      .repl        (repl),
      .value       (values[i]),
      .tok         (toks[i]),
      .hit         (hits[i])
    );
  end

  // token holder's code, at most one token is live
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_value = sel_value | (toks[i] ? values[i] : '0);
    end
  end

  assign any_hit   = |hits;
  assign cnt_m1    = count - CNT_W'(1);
  assign at_last   = (CNT_W'(idx) == cnt_m1);
  assign load_ok   = !rsp_valid || rsp_ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    act_next      = act;
    key_next      = key;
    repl_next     = repl;
    pend_next     = pend;
    rsp_next      = rsp;
    rsp_load      = 1'b0;
    ctrl.value_op = olt_pkg::CELL_HOLD;
    ctrl.tok_op   = olt_pkg::TOK_HOLD;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          act_next  = cmd.action;
          key_next  = cmd.code;
          repl_next = cmd.replacement;
          unique case (cmd.action)
            olt_pkg::ACT_INSERT: begin
              if (full) begin
                pend_next = olt_pkg::ST_FULL;
              end else begin
                // whole row moves one place back, head takes the code
                ctrl.value_op = olt_pkg::CELL_SHIFT;
                count_next    = count + CNT_W'(1);
                pend_next     = olt_pkg::ST_OK;
              end
              state_next = S_DONE;
            end
            olt_pkg::ACT_SEARCH, olt_pkg::ACT_MODIFY, olt_pkg::ACT_DELETE: begin
              if (empty) begin
                pend_next  = olt_pkg::ST_NOT_FOUND;
                state_next = S_DONE;
              end else begin
                ctrl.tok_op = olt_pkg::TOK_START;
                idx_next    = '0;
                state_next  = S_SCAN;
              end
            end
            olt_pkg::ACT_LIST: begin
              if (empty) begin
                pend_next  = olt_pkg::ST_EMPTY;
                state_next = S_DONE;
              end else begin
                ctrl.tok_op = olt_pkg::TOK_START;
                idx_next    = '0;
                state_next  = S_LIST;
              end
            end
            default: begin
              // unused action codes
              pend_next  = olt_pkg::ST_NOT_FOUND;
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (any_hit) begin
          unique case (act)
            olt_pkg::ACT_MODIFY: begin
              ctrl.value_op = olt_pkg::CELL_WRITE;
              ctrl.tok_op   = olt_pkg::TOK_CLEAR;
              pend_next     = olt_pkg::ST_OK;
              state_next    = S_DONE;
            end
            olt_pkg::ACT_DELETE: begin
              // token stays on the hole, the pull walk closes it
              state_next = S_PULL;
            end
            default: begin
              ctrl.tok_op = olt_pkg::TOK_CLEAR;
              pend_next   = olt_pkg::ST_OK;
              state_next  = S_DONE;
            end
          endcase
        end else if (at_last) begin
          ctrl.tok_op = olt_pkg::TOK_CLEAR;
          pend_next   = olt_pkg::ST_NOT_FOUND;
          state_next  = S_DONE;
        end else begin
          ctrl.tok_op = olt_pkg::TOK_STEP;
          idx_next    = idx + IDX_W'(1);
        end
      end

      S_PULL: begin
        if (at_last) begin
          ctrl.tok_op = olt_pkg::TOK_CLEAR;
          count_next  = cnt_m1;
          pend_next   = olt_pkg::ST_OK;
          state_next  = S_DONE;
        end else begin
          ctrl.value_op = olt_pkg::CELL_PULL;
          ctrl.tok_op   = olt_pkg::TOK_STEP;
          idx_next      = idx + IDX_W'(1);
        end
      end

      S_LIST: begin
        if (load_ok) begin
          rsp_load           = 1'b1;
          rsp_next.status    = olt_pkg::ST_OK;
          rsp_next.value     = sel_value;
          rsp_next.last      = at_last;
          rsp_next.occupancy = olt_pkg::OCC_W'(count);
          if (at_last) begin
            ctrl.tok_op = olt_pkg::TOK_CLEAR;
            state_next  = S_IDLE;
          end else begin
            ctrl.tok_op = olt_pkg::TOK_STEP;
            idx_next    = idx + IDX_W'(1);
          end
        end
      end

      S_DONE: begin
        if (load_ok) begin
          rsp_load           = 1'b1;
          rsp_next.status    = pend;
          rsp_next.value     = '0;
          rsp_next.last      = 1'b1;
          rsp_next.occupancy = olt_pkg::OCC_W'(count);
          state_next         = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    act  <= act_next;
    key  <= key_next;
    repl <= repl_next;
    pend <= pend_next;
    rsp  <= rsp_next;
  end

  // at most one cell carries the token
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(toks))
    else $error("more than one scan token in the cell row");

  // no token left behind once the sequencer is idle
  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (toks == '0))
    else $error("scan token live while idle");

  // count stays within the row
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // a beat that is not last only comes from a list walk
  a_not_last_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> (rsp.status == olt_pkg::ST_OK))
    else $error("non-final beat without ok status");

  // the token moves only during a scan, pull or list walk
  a_token_moves: assert property (@(posedge clk) disable iff (rst)
    (ctrl.tok_op == olt_pkg::TOK_STEP) |->
      (state == S_SCAN || state == S_PULL || state == S_LIST))
    else $error("token step outside a walk");

endmodule

`default_nettype wire
